>>> src/stereo_feedback_delay_unit_defines.svh
// assertion macros for the stereo feedback delay unit checker
// no dependencies; included by the checker file only
`ifndef STEREO_FEEDBACK_DELAY_UNIT_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed in %m");

// next-cycle implication, disabled while reset is low
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed in %m");

`endif

>>> src/sfd_pkg.sv
// shared constants, types and register indexes of the stereo feedback delay unit
// no dependencies
package sfd_pkg;

    localparam int MAX_DELAY   = 65536;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(MAX_DELAY);
    localparam int GAIN_FRAC   = 16;
    localparam int FB_W        = 16;
    localparam int MIX_W       = 17;
    localparam int DELAY_W     = 16;
    localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MONO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 3'd4;

    localparam logic [FB_W-1:0]    FB_LIMIT    = 16'd62259;
    localparam logic [MIX_W-1:0]   MIX_ONE     = 17'd65536;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd22050;
    localparam logic [FB_W-1:0]    FB_RESET    = 16'd32768;
    localparam logic [MIX_W-1:0]   MIX_RESET   = 17'd32768;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_W-1:0]             addr_t;

    // per-beat control handed from the top level to each channel datapath
    typedef struct packed {
        logic             capture;   // latch this cycle's store value for the next beat
        logic             fwd_hit;   // stage-1 beat reads the forwarded value
        logic             entry_ok;  // stage-1 read address was written since reset
        logic             load;      // stage 1 moves into stage 2
        logic             en;        // stage-1 beat is processed, not bypassed
        logic [FB_W-1:0]  fb;        // clamped feedback gain
        logic [MIX_W-1:0] mix;       // clamped wet share
    } sfd_ctl_t;

endpackage

>>> src/sfd_ram.sv
// generic simple dual-port ram, one write port, one read port with registered data
// no dependencies
module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sfd_chan.sv
// one channel of the echo datapath: delayed-sample select, gain products,
// rounding and saturation; depends on sfd_pkg
module sfd_chan (
    input  logic              aclk,
    input  sfd_pkg::sfd_ctl_t ctl,
    input  sfd_pkg::sample_t  s1_sample,
    input  sfd_pkg::sample_t  rd_data,
    output sfd_pkg::sample_t  store_data,
    output sfd_pkg::sample_t  out_sample
);
    import sfd_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + FB_W + 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int WET_W  = DIFF_W + MIX_W + 1;
    localparam int ACC_W  = WET_W + 1;
    localparam int RND_W  = ACC_W - GAIN_FRAC;
    localparam int FBR_W  = PROD_W - GAIN_FRAC;

    localparam longint HI_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(HI_L);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-HI_L - 64'sd1);
    localparam longint HALF_L = 64'sd1 <<< (GAIN_FRAC - 1);

    function automatic sample_t sat_sample(input logic signed [RND_W-1:0] v);
        sample_t r;
        if (v > SAT_HI) begin
            r = SAMPLE_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = SAMPLE_BITS'(SAT_LO);
        end else begin
            r = SAMPLE_BITS'(v);
        end
        return r;
    endfunction

    sample_t                    fwd_data_reg;
    sample_t                    s2_dry_reg;
    logic signed [WET_W-1:0]    s2_wet_reg;
    logic                       s2_en_reg;

    sample_t                    delayed;
    logic signed [FB_W:0]       fb_s;
    logic signed [MIX_W:0]      mix_s;
    logic signed [PROD_W-1:0]   fb_prod;
    logic signed [PROD_W-1:0]   fb_sum;
    logic signed [FBR_W-1:0]    fb_rnd;
    logic signed [RND_W-1:0]    store_sum;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [WET_W-1:0]    wet;
    logic signed [ACC_W-1:0]    acc;
    logic signed [RND_W-1:0]    acc_rnd;

    // stage 1: pick the delayed sample, form both gain products
    always_comb begin
        if (ctl.fwd_hit) begin
            delayed = fwd_data_reg;
        end else if (ctl.entry_ok) begin
            delayed = rd_data;
        end else begin
            delayed = '0;
        end
    end

    assign fb_s    = {1'b0, ctl.fb};
    assign mix_s   = {1'b0, ctl.mix};
    assign fb_prod = PROD_W'(delayed) * PROD_W'(fb_s);
    assign fb_sum  = fb_prod + PROD_W'(HALF_L);
    assign fb_rnd  = fb_sum[PROD_W-1:GAIN_FRAC];
    assign store_sum  = RND_W'(s1_sample) + RND_W'(fb_rnd);
    assign store_data = sat_sample(store_sum);

    // dry*(1-mix) + delayed*mix == dry + (delayed-dry)*mix
    assign diff = DIFF_W'(delayed) - DIFF_W'(s1_sample);
    assign wet  = WET_W'(diff) * WET_W'(mix_s);

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            fwd_data_reg <= store_data;
        end
        if (ctl.load) begin
            s2_dry_reg <= s1_sample;
            s2_wet_reg <= wet;
            s2_en_reg  <= ctl.en;
        end
    end

    // stage 2: sum, round half up, saturate; a bypassed beat passes its dry sample
    assign acc     = ACC_W'(s2_wet_reg) + (ACC_W'(s2_dry_reg) <<< GAIN_FRAC) + ACC_W'(HALF_L);
    assign acc_rnd = acc[ACC_W-1:GAIN_FRAC];
    assign out_sample = s2_en_reg ? sat_sample(acc_rnd) : s2_dry_reg;

endmodule

>>> src/stereo_feedback_delay_unit.sv
// stereo feedback echo: top level with handshake, config registers and delay stores
// depends on sfd_pkg, sfd_ram and sfd_chan
//
// usage
//   s_ channel: one beat carries a stereo pair, left in the low half of
//   s_tdata, right in the high half, both signed q1.23. m_ channel returns
//   one processed pair per input beat in the same layout and order.
//   configuration goes through cfg_we/cfg_index/cfg_data, one register per
//   write, and is meant to change only while no beat is in flight.
// pipeline and throughput
//   one beat per clock sustained while m_tready stays high. an accepted
//   beat passes stage 1 (reads the stores), stage 2 (sums) and then the
//   output register. the rate is set by the one-read, one-write port
//   pair of each delay store and the forwarding loop that hands a fresh
//   store value to the very next beat.
// reset
//   synchronous active-low reset empties the pipe, zeroes the write
//   position and loads the config defaults. the stores are not swept:
//   a fill flag makes every entry not yet written since reset read as zero.
// back-pressure
//   with m_tready low the output register holds; stages 1 and 2 keep
//   filling, so up to two more beats are accepted before s_tready drops.
module stereo_feedback_delay_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfd_pkg::TDATA_W-1:0]     s_tdata,    // left_in, right_in
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfd_pkg::TDATA_W-1:0]     m_tdata,    // left_out, right_out
    // configuration writes
    input  logic                            cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfd_pkg::*;

    // config registers
    logic               enable_reg;
    logic               mono_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [FB_W-1:0]    fb_reg;
    logic [MIX_W-1:0]   mix_reg;

    // control state
    logic  s1_v_reg, s1_v_next;
    logic  s2_v_reg, s2_v_next;
    logic  m_v_reg,  m_v_next;
    addr_t wp_reg,   wp_next;
    logic  filled_reg, filled_next;

    // stage 1 payload
    sample_t s1_left_reg;
    sample_t s1_right_reg;
    addr_t   s1_wp_reg;
    logic    s1_en_reg;
    logic    s1_ok_reg;
    logic    s1_fwd_reg;

    logic [TDATA_W-1:0] m_tdata_reg;

    // handshake and pipeline advance
    logic accept;
    logic adv1;
    logic adv2;

    // addressing
    logic [FB_W-1:0]  fb_c;
    logic [MIX_W-1:0] mix_c;
    addr_t d_c;
    addr_t rd_addr;
    logic  st_write;
    logic  fwd_hit;

    sample_t in_left;
    sample_t in_right;
    sample_t left_rd;
    sample_t right_rd;
    sample_t left_store;
    sample_t right_store;
    sample_t left_out;
    sample_t right_out;

    sfd_ctl_t ctl;

    assign in_left  = s_tdata[SAMPLE_BITS-1:0];
    assign in_right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // stage 2 drains into the output register, stage 1 into stage 2
    assign adv2     = s2_v_reg && (!m_v_reg || m_tready);
    assign adv1     = s1_v_reg && (!s2_v_reg || adv2);
    assign s_tready = !s1_v_reg || adv1;
    assign accept   = s_tvalid && s_tready;

    // gain and delay clamps
    assign fb_c  = (fb_reg > FB_LIMIT) ? FB_LIMIT : fb_reg;
    assign mix_c = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
    assign d_c   = (int'(delay_reg) > MAX_DELAY - 1) ? ADDR_W'(MAX_DELAY - 1)
                                                      : ADDR_W'(delay_reg);

    // read position, circular over the store depth
    always_comb begin
        if (wp_reg >= d_c) begin
            rd_addr = wp_reg - d_c;
        end else begin
            rd_addr = wp_reg + ADDR_W'(MAX_DELAY) - d_c;
        end
    end

    // a processed stage-1 beat writes its store value as it leaves; a beat accepted on that
    // same edge at that same address takes the value from the forward register
    assign st_write = adv1 && s1_en_reg;
    assign fwd_hit  = st_write && (s1_wp_reg == rd_addr);

    always_comb begin
        ctl.capture  = accept && fwd_hit;
        ctl.fwd_hit  = s1_fwd_reg;
        ctl.entry_ok = s1_ok_reg;
        ctl.load     = adv1;
        ctl.en       = s1_en_reg;
        ctl.fb       = fb_c;
        ctl.mix      = mix_c;
    end

    // control next state
    always_comb begin
        s1_v_next   = s1_v_reg;
        s2_v_next   = s2_v_reg;
        m_v_next    = m_v_reg;
        wp_next     = wp_reg;
        filled_next = filled_reg;

        if (accept) begin
            s1_v_next = 1'b1;
        end else if (adv1) begin
            s1_v_next = 1'b0;
        end

        if (adv1) begin
            s2_v_next = 1'b1;
        end else if (adv2) begin
            s2_v_next = 1'b0;
        end

        if (adv2) begin
            m_v_next = 1'b1;
        end else if (m_tready) begin
            m_v_next = 1'b0;
        end

        // write position moves only for processed beats
        if (accept && enable_reg) begin
            if (wp_reg == ADDR_W'(MAX_DELAY - 1)) begin
                wp_next     = '0;
                filled_next = 1'b1;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            m_v_reg    <= 1'b0;
            wp_reg     <= '0;
            filled_reg <= 1'b0;
            enable_reg <= 1'b0;
            mono_reg   <= 1'b0;
            delay_reg  <= DELAY_RESET;
            fb_reg     <= FB_RESET;
            mix_reg    <= MIX_RESET;
        end else begin
            s1_v_reg   <= s1_v_next;
            s2_v_reg   <= s2_v_next;
            m_v_reg    <= m_v_next;
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_ENABLE:   enable_reg <= cfg_data[0];
                    REG_MONO:     mono_reg   <= cfg_data[0];
                    REG_DELAY:    delay_reg  <= cfg_data[DELAY_W-1:0];
                    REG_FEEDBACK: fb_reg     <= cfg_data[FB_W-1:0];
                    REG_MIX:      mix_reg    <= cfg_data[MIX_W-1:0];
                    default:      ;  // unknown index, write dropped
                endcase
            end
        end
    end

    // stage 1 payload captured on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_left_reg  <= in_left;
            s1_right_reg <= mono_reg ? in_left : in_right;
            s1_wp_reg    <= wp_reg;
            s1_en_reg    <= enable_reg;
            // entries at or past the write position are unwritten until the first wrap
            s1_ok_reg    <= filled_reg || (rd_addr < wp_reg);
            s1_fwd_reg   <= fwd_hit;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_tdata_reg <= TDATA_W'({right_out, left_out});
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_tdata_reg;

    // delay stores, read on accept, written as each processed stage-1 beat retires
    sfd_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_DELAY)
    ) u_left_store (
        .clk   (aclk),
        .we    (st_write),
        .waddr (s1_wp_reg),
        .wdata (left_store),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (left_rd)
    );

    sfd_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_DELAY)
    ) u_right_store (
        .clk   (aclk),
        .we    (st_write),
        .waddr (s1_wp_reg),
        .wdata (right_store),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (right_rd)
    );

    // channel datapaths
    sfd_chan u_left_chan (
        .aclk       (aclk),
        .ctl        (ctl),
        .s1_sample  (s1_left_reg),
        .rd_data    (left_rd),
        .store_data (left_store),
        .out_sample (left_out)
    );

    sfd_chan u_right_chan (
        .aclk       (aclk),
        .ctl        (ctl),
        .s1_sample  (s1_right_reg),
        .rd_data    (right_rd),
        .store_data (right_store),
        .out_sample (right_out)
    );

endmodule

>>> src/sfd_checker.sv
// port-level checks of the stereo feedback delay unit, bound to the top level
// depends on sfd_pkg and stereo_feedback_delay_unit_defines.svh
`include "stereo_feedback_delay_unit_defines.svh"

module sfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sfd_pkg::TDATA_W-1:0]     s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sfd_pkg::TDATA_W-1:0]     m_tdata,
    input logic                            cfg_we,
    input logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfd_pkg::*;

    // beats accepted but not yet delivered
    logic [2:0] inflight_reg, inflight_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (out_beat && !in_beat) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `SFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SFD_ASSERT_NOW(a_ready_when_out_empty, aclk, aresetn, !m_tvalid, s_tready)
    `SFD_ASSERT_NOW(a_no_orphan_out, aclk, aresetn, m_tvalid, inflight_reg != 3'd0)
    `SFD_ASSERT_NOW(a_pipe_depth, aclk, aresetn, 1'b1, inflight_reg <= 3'd3)

endmodule

bind stereo_feedback_delay_unit sfd_checker u_sfd_checker (.*);

>>> tb/tb_stereo_feedback_delay_unit.sv
// self-checking testbench for the stereo feedback delay unit: directed corner cases, then
// randomized register settings and sample streams with paced traffic on both stream ports, then back-pressure
// depends on sfd_pkg and stereo_feedback_delay_unit
`timescale 1ns / 1ps

module tb_stereo_feedback_delay_unit;
    import sfd_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          RESET_CYCLES = 4;
    localparam int unsigned RUN_LIMIT = 400000;
    localparam int          LONG_HOLD = 400;    // receiver hold-off for the fill-up test
    localparam int          DRAIN_CYCLES = 6;   // two-stage pipe plus output register, with slack
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_BEATS = 200;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // one stereo pair, left in the low bits as on the stream ports
    typedef struct packed {
        sample_t right;
        sample_t left;
    } pair_t;

    typedef enum {RX_FREE, RX_RUNS, RX_CHOPPY} rx_pacing_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    stereo_feedback_delay_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // left_in, right_in
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // left_out, right_out
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // echo predictor: own copy of the delay stores, write pointer and registers
    // ------------------------------------------------------------------
    sample_t          echo_store [2][MAX_DELAY];   // [0] left, [1] right
    addr_t            echo_wr_pos;
    bit               cfg_enable;
    bit               cfg_mono;
    logic [DELAY_W-1:0] cfg_delay;
    logic [FB_W-1:0]  cfg_fb;
    logic [MIX_W-1:0] cfg_mix;

    pair_t            expected_pairs [$];

    // bookkeeping for the summary and the verdict
    int               mismatch_count;
    int               beats_sent;
    int               results_checked;
    int               settings_applied;
    int               input_stall_cycles;
    int unsigned      cycle_count;

    // traffic shaping knobs shared by the stimulus and the receiver
    bit               gaps_on;
    int               burst_left;
    rx_pacing_t       rx_mode;
    bit               hold_request;

    function automatic void reset_echo_model();
        for (int i = 0; i < MAX_DELAY; i++) begin
            echo_store[0][i] = '0;
            echo_store[1][i] = '0;
        end
        echo_wr_pos = '0;
        cfg_enable = 1'b0;
        cfg_mono = 1'b0;
        cfg_delay = DELAY_RESET;
        cfg_fb = FB_RESET;
        cfg_mix = MIX_RESET;
    endfunction

    function automatic void mirror_register(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLE:   cfg_enable = data[0];
            REG_MONO:     cfg_mono = data[0];
            REG_DELAY:    cfg_delay = data[DELAY_W-1:0];
            REG_FEEDBACK: cfg_fb = data[FB_W-1:0];
            REG_MIX:      cfg_mix = data[MIX_W-1:0];
            default: ;    // unused indexes do nothing
        endcase
    endfunction

    // floor((x + 0.5 lsb) / 2^16), i.e. round half up
    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> GAIN_FRAC;
    endfunction

    function automatic sample_t clip_sample(longint v);
        if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
        return sample_t'(v);
    endfunction

    function automatic pair_t predict_echo(sample_t l_in, sample_t r_in);
        sample_t dry [2];
        sample_t wet [2];
        pair_t   res;
        longint  fb;
        longint  mix;
        longint  delayed;
        addr_t   rd_pos;
        dry[0] = l_in;
        dry[1] = cfg_mono ? l_in : r_in;
        if (!cfg_enable) begin
            // bypass: stores and pointer stay put
            res.left = dry[0];
            res.right = dry[1];
            return res;
        end
        fb = (cfg_fb > FB_LIMIT) ? longint'(FB_LIMIT) : longint'(cfg_fb);
        mix = (cfg_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(cfg_mix);
        // a 16-bit delay never exceeds the store depth, so the pointer just wraps
        rd_pos = echo_wr_pos - addr_t'(cfg_delay);
        for (int ch = 0; ch < 2; ch++) begin
            // read before write, so zero delay sees the entry from a full lap ago
            delayed = longint'(echo_store[ch][rd_pos]);
            wet[ch] = clip_sample(round_q16(longint'(dry[ch]) * (longint'(MIX_ONE) - mix)
                                            + delayed * mix));
            echo_store[ch][echo_wr_pos] = clip_sample(longint'(dry[ch])
                                                      + round_q16(delayed * fb));
        end
        echo_wr_pos = echo_wr_pos + 1'b1;
        res.left = wet[0];
        res.right = wet[1];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // clock, watchdog and stall monitor
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_pairs.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // input side held off by the block
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready)
            input_stall_cycles <= input_stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // result checker: every output beat against the oldest prediction
    // ------------------------------------------------------------------
    pair_t got_pair;
    pair_t want_pair;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_pair = pair_t'(m_tdata);
            if (expected_pairs.size() == 0) begin
                $error("result beat with nothing expected: left_out %0d right_out %0d",
                       got_pair.left, got_pair.right);
                mismatch_count++;
            end else begin
                want_pair = expected_pairs.pop_front();
                results_checked++;
                if (got_pair.left !== want_pair.left) begin
                    $error("left_out mismatch: expected %0d actual %0d",
                           want_pair.left, got_pair.left);
                    mismatch_count++;
                end
                if (got_pair.right !== want_pair.right) begin
                    $error("right_out mismatch: expected %0d actual %0d",
                           want_pair.right, got_pair.right);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver pacing: free running, runs of ready/stall, or choppy random,
    // plus one long hold-off on request to fill the pipe
    // ------------------------------------------------------------------
    initial begin : rx_pacing
        int hold_left;
        int run_left;
        bit run_ready;
        hold_left = 0;
        run_left = 0;
        run_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_ready = !run_ready;
                            run_left = run_ready ? $urandom_range(1, 20) : $urandom_range(1, 6);
                        end
                        run_left--;
                        m_tready <= run_ready;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------

    // present one pair and hold it until taken; s_tvalid stays high on return,
    // so the caller either sends again in the same step or lowers it
    task automatic send_pair(input sample_t l, input sample_t r);
        pair_t beat;
        beat.left = l;
        beat.right = r;
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_pairs.insert(expected_pairs.size(), predict_echo(l, r));
        beats_sent++;
    endtask

    // bursts of random length, with an idle gap after each burst when gaps are on
    task automatic send_paced(input sample_t l, input sample_t r);
        int gap;
        send_pair(l, r);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // stop offering, wait out every pending result, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        mirror_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // full register set; junk above the used bits must be dropped by the block
    task automatic set_echo(input bit en, input bit mono, input logic [DELAY_W-1:0] delay,
                            input logic [FB_W-1:0] fb, input logic [MIX_W-1:0] mix);
        drain();
        write_reg(REG_ENABLE, {16'($urandom()), en});
        write_reg(REG_MONO, {16'($urandom()), mono});
        write_reg(REG_DELAY, {1'($urandom()), delay});
        write_reg(REG_FEEDBACK, {1'($urandom()), fb});
        write_reg(REG_MIX, mix);
        settings_applied++;
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'(int'($urandom_range(0, 512)) - 256);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // registers at reset: echo off, so samples come straight through
    task automatic test_bypass_defaults();
        send_paced(SAMPLE_MAX, SAMPLE_MIN);
        send_paced(SAMPLE_MIN, SAMPLE_MAX);
        send_paced('0, '1);
        send_paced(sample_t'(1), SAMPLE_MIN);
        drain();
    endtask

    // mono in bypass copies left to right; writes to unused indexes change nothing
    task automatic test_mono_bypass();
        write_reg(REG_MONO, 17'(1));
        for (int i = int'(REG_MIX) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), '1);
        send_paced(SAMPLE_MIN, SAMPLE_MAX);
        send_paced(SAMPLE_MAX, '0);
        send_paced(sample_t'(-5), sample_t'(77));
        drain();
        write_reg(REG_MONO, '0);
    endtask

    // only enable written: reset delay, feedback and mix take effect (half dry, empty store)
    task automatic test_reset_gains();
        write_reg(REG_ENABLE, 17'(1));
        send_paced(SAMPLE_MAX, SAMPLE_MIN);
        send_paced(sample_t'(3), sample_t'(-3));
        send_paced(sample_t'(-1), sample_t'(1));
        drain();
    endtask

    // oversized gains clamp; full-scale input with max feedback saturates the store
    task automatic test_saturation();
        set_echo(1'b1, 1'b0, 16'd1, '1, '1);
        repeat (4) send_paced(SAMPLE_MAX, SAMPLE_MIN);
        repeat (4) send_paced(SAMPLE_MIN, SAMPLE_MAX);
        drain();
    endtask

    // zero delay reads the slot about to be written; all-dry mix
    task automatic test_zero_delay();
        set_echo(1'b1, 1'b0, '0, FB_LIMIT, '0);
        send_paced(SAMPLE_MAX, sample_t'(12345));
        send_paced(SAMPLE_MIN, sample_t'(-12345));
        send_paced(sample_t'(1), sample_t'(-1));
        drain();
    endtask

    // mono with the echo on: right store fed from the left input, fully wet
    task automatic test_mono_echo();
        set_echo(1'b1, 1'b1, 16'd2, FB_RESET, MIX_ONE);
        repeat (4) send_paced(rand_sample(), rand_sample());
        drain();
    endtask

    // ------------------------------------------------------------------
    // randomized phases, each with its own register setting and pacing
    // ------------------------------------------------------------------
    task automatic randomize_setting(input int phase);
        logic [DELAY_W-1:0] delay;
        logic [FB_W-1:0]    fb;
        logic [MIX_W-1:0]   mix;
        bit                 en;
        case (phase)
            // extremes first
            0: set_echo(1'b1, 1'b0, '0, '1, '1);
            1: set_echo(1'b1, 1'b1, '1, '0, '0);
            2: set_echo(1'b1, 1'b0, 16'd1, FB_LIMIT, MIX_ONE);
            default: begin
                en = ($urandom_range(0, 4) != 0);
                case ($urandom_range(0, 9))
                    7, 8:    delay = DELAY_W'($urandom_range(41, 4000));
                    9:       delay = '1 - DELAY_W'($urandom_range(0, 3));
                    default: delay = DELAY_W'($urandom_range(0, 40));
                endcase
                case ($urandom_range(0, 9))
                    7:       fb = FB_LIMIT;
                    8:       fb = FB_W'($urandom_range(int'(FB_LIMIT) + 1, 65535));
                    9:       fb = '0;
                    default: fb = FB_W'($urandom_range(0, int'(FB_LIMIT)));
                endcase
                case ($urandom_range(0, 9))
                    7:       mix = MIX_ONE;
                    8:       mix = '0;
                    9:       mix = MIX_W'($urandom_range(int'(MIX_ONE) + 1, 131071));
                    default: mix = MIX_W'($urandom_range(0, int'(MIX_ONE)));
                endcase
                set_echo(en, 1'($urandom()), delay, fb, mix);
            end
        endcase
        // vary the traffic shape per phase, including stretches with no idling at all
        gaps_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
            0:       rx_mode = RX_FREE;
            1:       rx_mode = RX_RUNS;
            default: rx_mode = RX_CHOPPY;
        endcase
    endtask

    task automatic test_random_echo();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomize_setting(p);
            for (int i = 0; i < PHASE_BEATS; i++)
                send_paced(rand_sample(), rand_sample());
            drain();
        end
    endtask

    // receiver holds off for a long stretch while beats keep coming, so the pipe
    // fills and s_tready has to drop; nothing may be lost or duplicated
    task automatic test_backpressure();
        set_echo(1'b1, 1'b0, 16'd3, 16'd60000, 17'd40000);
        gaps_on = 1'b0;
        rx_mode = RX_RUNS;
        hold_request = 1'b1;
        repeat (64) send_paced(rand_sample(), rand_sample());
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // every input known from time zero
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        mismatch_count = 0;
        beats_sent = 0;
        results_checked = 0;
        settings_applied = 0;
        input_stall_cycles = 0;
        gaps_on = 1'b1;
        burst_left = 0;
        rx_mode = RX_RUNS;
        hold_request = 1'b0;
        reset_echo_model();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_bypass_defaults();
        test_mono_bypass();
        test_reset_gains();
        test_saturation();
        test_zero_delay();
        test_mono_echo();
        test_random_echo();
        test_backpressure();
        drain();

        $display("covered %0d beats and %0d checked results over %0d register settings",
                 beats_sent, results_checked, settings_applied);
        $display("input side was held off for %0d cycles in total", input_stall_cycles);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/sfd_pkg.sv
src/sfd_ram.sv
src/sfd_chan.sv
src/stereo_feedback_delay_unit.sv
src/sfd_checker.sv
tb/tb_stereo_feedback_delay_unit.sv
